// ===== rtl/core/bma_pkg.sv =====
// ----------------------------------------------------------------------------
// bma_pkg
// Shared types and constants of the boxcar moving average filter.
// ----------------------------------------------------------------------------
package bma_pkg;

    // Width of the window length register.
    localparam int CFG_BITS = 5;

    typedef logic [CFG_BITS-1:0] t_cfg;

    // Window length after reset.
    localparam t_cfg WIN_RESET = t_cfg'(3);

endpackage

// ===== rtl/core/bma_front.sv =====
// ----------------------------------------------------------------------------
// bma_front
// Sample ring and running sum. Accepts one sample per cycle unless the queue
// is full, replaces the oldest ring entry and hands the new sum to the queue.
// ----------------------------------------------------------------------------
module bma_front
    import bma_pkg::*;
#(
    parameter int WINDOW_MAX  = 16,
    parameter int SAMPLE_BITS = 16,
    parameter int SUM_BITS    = 21
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  t_cfg                       i_win,
    input  logic                       i_q_full,
    output logic                       o_q_push,
    output logic [SUM_BITS-1:0]        o_q_sum
);

    localparam int POS_BITS = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int EXT_BITS = SUM_BITS - SAMPLE_BITS;

    logic [SAMPLE_BITS-1:0] r_ring [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]  r_valid;
    logic [POS_BITS-1:0]    r_pos;
    logic [POS_BITS-1:0]    n_pos;
    logic [SUM_BITS-1:0]    r_sum;
    logic [SUM_BITS-1:0]    n_sum;
    logic [SAMPLE_BITS-1:0] r_rd_data;
    logic                   r_rd_ok;
    logic                   r_byp;
    logic [SAMPLE_BITS-1:0] r_byp_data;
    logic [SAMPLE_BITS-1:0] old_entry;
    logic [POS_BITS-1:0]    rd_addr;
    logic [POS_BITS:0]      pos_inc;
    logic                   accept;

    assign accept = i_push && !i_q_full;

    always_comb begin
        pos_inc = {1'b0, r_pos} + (POS_BITS+1)'(1);
        if (32'(pos_inc) >= 32'(i_win)) begin
            n_pos = '0;
        end else begin
            n_pos = pos_inc[POS_BITS-1:0];
        end
    end

    // The ring is read ahead through a registered read at the position the next
    // sample will use, so the old entry is ready when that sample arrives.
    assign rd_addr = accept ? n_pos : r_pos;

    always_comb begin
        if (r_byp) begin
            old_entry = r_byp_data;
        end else if (r_rd_ok) begin
            old_entry = r_rd_data;
        end else begin
            old_entry = '0;
        end
    end

    assign n_sum = r_sum - {{EXT_BITS{old_entry[SAMPLE_BITS-1]}}, old_entry}
                         + {{EXT_BITS{i_sample[SAMPLE_BITS-1]}}, i_sample};

    assign o_q_push = accept;
    assign o_q_sum  = n_sum;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ring[r_pos] <= i_sample;
        end
        r_rd_data  <= r_ring[rd_addr];
        r_byp_data <= i_sample;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_pos   <= '0;
            r_sum   <= '0;
            r_rd_ok <= 1'b0;
            r_byp   <= 1'b0;
        end else begin
            if (accept) begin
                r_valid[r_pos] <= 1'b1;
                r_pos          <= n_pos;
                r_sum          <= n_sum;
            end
            r_rd_ok <= r_valid[rd_addr];
            // A write to the entry being fetched wins over the stale read.
            r_byp   <= accept && (rd_addr == r_pos);
        end
    end

endmodule

// ===== rtl/core/bma_queue.sv =====
// ----------------------------------------------------------------------------
// bma_queue
// Two-entry queue of window sums between the accumulator and the divider.
// ----------------------------------------------------------------------------
module bma_queue #(
    parameter int WIDTH = 21
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/core/bma_back.sv =====
// ----------------------------------------------------------------------------
// bma_back
// Divides each window sum by the window length, one quotient bit per cycle,
// saturates the quotient to the sample range and holds it for the consumer.
// ----------------------------------------------------------------------------
module bma_back
    import bma_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int SUM_BITS    = 21
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_empty,
    input  logic [SUM_BITS-1:0]           i_q_sum,
    output logic                          o_q_pop,
    input  t_cfg                          i_win,
    input  logic                          i_pop,
    output logic                          o_empty,
    output logic signed [SAMPLE_BITS-1:0] o_average
);

    localparam int CNT_BITS = $clog2(SUM_BITS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    localparam logic [SUM_BITS-1:0] POS_LIM =
        SUM_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic [SUM_BITS-1:0] NEG_LIM =
        SUM_BITS'(64'd1 << (SAMPLE_BITS - 1));
    localparam logic [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic [1:0]             r_state;
    logic [CNT_BITS-1:0]    r_cnt;
    logic                   r_neg;
    logic [SUM_BITS-1:0]    r_quo;
    logic [CFG_BITS-1:0]    r_rem;
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out;
    logic [CFG_BITS:0]      rem_shift;
    logic [CFG_BITS:0]      rem_sub;
    logic                   rem_ge;
    logic [SUM_BITS-1:0]    quo_neg;
    logic [SAMPLE_BITS-1:0] sat_val;
    logic                   out_free;

    assign o_q_pop   = (r_state == S_IDLE) && !i_q_empty;
    assign o_empty   = !r_out_valid;
    assign o_average = r_out;
    assign out_free  = !r_out_valid || i_pop;

    // Restoring division step: the remainder stays below the divisor.
    assign rem_shift = {r_rem, r_quo[SUM_BITS-1]};
    assign rem_sub   = rem_shift - {1'b0, i_win};
    assign rem_ge    = (rem_shift >= {1'b0, i_win});

    assign quo_neg = ~r_quo + SUM_BITS'(1);

    always_comb begin
        if (r_neg) begin
            sat_val = (r_quo > NEG_LIM) ? SAT_MIN : quo_neg[SAMPLE_BITS-1:0];
        end else begin
            sat_val = (r_quo > POS_LIM) ? SAT_MAX : r_quo[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_neg <= i_q_sum[SUM_BITS-1];
                r_quo <= i_q_sum[SUM_BITS-1] ? (~i_q_sum + SUM_BITS'(1)) : i_q_sum;
                r_rem <= '0;
            end
            S_DIV: begin
                r_rem <= rem_ge ? rem_sub[CFG_BITS-1:0] : rem_shift[CFG_BITS-1:0];
                r_quo <= {r_quo[SUM_BITS-2:0], rem_ge};
            end
            default: begin
                r_quo <= r_quo;
            end
        endcase
        if ((r_state == S_DONE) && out_free) begin
            r_out <= sat_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + CNT_BITS'(1);
                    if (r_cnt == CNT_BITS'(SUM_BITS - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/core/boxcar_moving_average.sv =====
// ----------------------------------------------------------------------------
// boxcar_moving_average
// Moving average over the last window_length signed samples, truncated
// toward zero and saturated to the sample range.
//
//   Channel   Direction  Handshake          Payload
//   -------   ---------  -----------------  ---------------------------
//   sample    in         push / full        i_sample
//   average   out        empty / pop        o_average
//   config    in         i_cfg_we           i_cfg_wdata (window length)
//
// The accumulator takes a sample in any cycle in which the two-entry sum
// queue has room. Each average then passes through the bit-serial divider
// (idle, divide and done states), which sets the sustained rate. Reset
// clears the ring through per-entry valid bits at once; no clearing pass is
// needed. A held result does not stop the divider from dividing the next
// sum; that quotient then waits in the done state until a pop frees the output.
// ----------------------------------------------------------------------------
module boxcar_moving_average
    import bma_pkg::*;
#(
    parameter int WINDOW_MAX  = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [SAMPLE_BITS-1:0] o_average,
    input  logic                          i_cfg_we,
    input  logic [CFG_BITS-1:0]           i_cfg_wdata
);

    localparam int SUM_BITS = SAMPLE_BITS + $clog2(WINDOW_MAX) + 1;

    t_cfg                r_cfg;
    t_cfg                win_eff;
    logic                q_push;
    logic [SUM_BITS-1:0] q_in;
    logic                q_full;
    logic                q_pop;
    logic                q_empty;
    logic [SUM_BITS-1:0] q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= WIN_RESET;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    // A zero window behaves as one; a window beyond the ring is clipped.
    always_comb begin
        if (r_cfg == '0) begin
            win_eff = t_cfg'(1);
        end else if (32'(r_cfg) > WINDOW_MAX) begin
            win_eff = t_cfg'(WINDOW_MAX);
        end else begin
            win_eff = r_cfg;
        end
    end

    bma_front #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_BITS    (SUM_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_sample (i_sample),
        .i_win    (win_eff),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_sum  (q_in)
    );

    bma_queue #(
        .WIDTH (SUM_BITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    bma_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_BITS    (SUM_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_sum   (q_out),
        .o_q_pop   (q_pop),
        .i_win     (win_eff),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_average (o_average)
    );

    assign full = q_full;

    // An accepted sample leaves a sum waiting in the queue.
    a_accept_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full) |=> !q_empty)
        else $error("accepted sample did not reach the sum queue");

    // The divider only takes sums that are there.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("divider took a sum from an empty queue");

    // Right after reset nothing is pending on either side.
    a_reset_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> (empty && !full && q_empty))
        else $error("block not clear after reset");

endmodule
